// ----- src/longest_consecutive_run_tracker_defines.svh -----
// Assertion macros for the longest consecutive run tracker.
// Depends on nothing; included by the modules that carry assertions.
`ifndef LONGEST_CONSECUTIVE_RUN_TRACKER_DEFINES_SVH
`define LONGEST_CONSECUTIVE_RUN_TRACKER_DEFINES_SVH
`ifndef ASSERT_OFF
// Checked on clk_i, skipped while rst_ni is low.
`define LCRT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
// Checked on clk_i at every edge, reset included.
`define LCRT_ASSERT_NR(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);
`else
`define LCRT_ASSERT(lbl, prop, msg)
`define LCRT_ASSERT_NR(lbl, prop, msg)
`endif
`endif

// ----- src/lcrt_pkg.sv -----
// Shared types for the longest consecutive run tracker.
// No dependencies; used by lcrt_front, lcrt_back and the top level.
package lcrt_pkg;

  // Range-edge flags computed when a word is accepted.
  typedef struct packed {
    logic at_bottom;
    logic at_top;
  } bound_flags_t;

  // Back end to front end control.
  typedef struct packed {
    logic clearing;
    logic pop;
  } back_ctrl_t;

endpackage

// ----- src/longest_consecutive_run_tracker.sv -----
// A new value passes through S_IDLE, S_CHK, S_BELOW, S_LO and S_HI; a duplicate ends at S_CHK.
// The back end takes the next value only once the last one is done, a pace set by the single
// read and single write port of the run-length table (three reads, up to three writes).
// Reset (rst_ni low, async) empties the queue and result register; a clearing pass
// then zeroes all 2^VALUE_BITS table entries, in_ready_o held low.
// Depends on lcrt_pkg, lcrt_front, lcrt_back.
module longest_consecutive_run_tracker #(
  parameter int unsigned VALUE_BITS = 10
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic [VALUE_BITS-1:0] value_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [VALUE_BITS:0]   longest_o,
  output logic [VALUE_BITS:0]   run_length_o,
  output logic                  duplicate_o
);

  // Front end takes words into a two-entry queue; the back end pops one
  // word at a time and walks the table: read v (duplicate check), read v-1,
  // read v+1 while marking v present, write the merged length at the low
  // end, then at the high end. Result sits in an output register so the
  // front keeps accepting while it waits.
  logic                   q_valid;
  logic [VALUE_BITS-1:0]  q_value;
  lcrt_pkg::bound_flags_t q_flags;
  lcrt_pkg::back_ctrl_t   back_ctrl;

  lcrt_front #(
    .VALUE_BITS (VALUE_BITS)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .value_i     (value_i),
    .q_valid_o   (q_valid),
    .q_value_o   (q_value),
    .q_flags_o   (q_flags),
    .back_ctrl_i (back_ctrl)
  );

  lcrt_back #(
    .VALUE_BITS (VALUE_BITS)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .q_valid_i    (q_valid),
    .q_value_i    (q_value),
    .q_flags_i    (q_flags),
    .back_ctrl_o  (back_ctrl),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .longest_o    (longest_o),
    .run_length_o (run_length_o),
    .duplicate_o  (duplicate_o)
  );

endmodule

// ----- src/lcrt_front.sv -----
// Front end: accepts input words, flags range edges, two-entry queue.
// Depends on lcrt_pkg.
module lcrt_front #(
  parameter int unsigned VALUE_BITS = 10
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_ready_o,
  input  logic [VALUE_BITS-1:0]   value_i,
  output logic                    q_valid_o,
  output logic [VALUE_BITS-1:0]   q_value_o,
  output lcrt_pkg::bound_flags_t  q_flags_o,
  input  lcrt_pkg::back_ctrl_t    back_ctrl_i
);

  logic [VALUE_BITS-1:0]  val_q [2];
  lcrt_pkg::bound_flags_t flg_q [2];
  lcrt_pkg::bound_flags_t flg_in;
  logic                   wr_ptr_q, wr_ptr_d;
  logic                   rd_ptr_q, rd_ptr_d;
  logic [1:0]             cnt_q, cnt_d;
  logic                   push, pop;

  assign in_ready_o = (cnt_q != 2'd2) && !back_ctrl_i.clearing;
  assign push       = in_valid_i && in_ready_o;
  assign pop        = back_ctrl_i.pop && q_valid_o;

  assign flg_in.at_bottom = (value_i == '0);
  assign flg_in.at_top    = (value_i == '1);

  assign q_valid_o = (cnt_q != 2'd0);
  assign q_value_o = val_q[rd_ptr_q];
  assign q_flags_o = flg_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop ? ~rd_ptr_q : rd_ptr_q;
    unique case ({push, pop})
      2'b10:   cnt_d = cnt_q + 2'd1;
      2'b01:   cnt_d = cnt_q - 2'd1;
      default: cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      val_q[wr_ptr_q] <= value_i;
      flg_q[wr_ptr_q] <= flg_in;
    end
  end

endmodule

// ----- src/lcrt_back.sv -----
// Back end: run-length table memory, read/merge/write sequencer, result register.
// Depends on lcrt_pkg and longest_consecutive_run_tracker_defines.svh.
`include "longest_consecutive_run_tracker_defines.svh"
module lcrt_back #(
  parameter int unsigned VALUE_BITS = 10
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    q_valid_i,
  input  logic [VALUE_BITS-1:0]   q_value_i,
  input  lcrt_pkg::bound_flags_t  q_flags_i,
  output lcrt_pkg::back_ctrl_t    back_ctrl_o,
  output logic                    out_valid_o,
  input  logic                    out_ready_i,
  output logic [VALUE_BITS:0]     longest_o,
  output logic [VALUE_BITS:0]     run_length_o,
  output logic                    duplicate_o
);

  localparam int unsigned LenW  = VALUE_BITS + 1;
  localparam int unsigned Depth = 2 ** VALUE_BITS;

  typedef enum logic [5:0] {
    S_CLEAR = 6'b000001,
    S_IDLE  = 6'b000010,
    S_CHK   = 6'b000100,
    S_BELOW = 6'b001000,
    S_LO    = 6'b010000,
    S_HI    = 6'b100000
  } state_e;

  state_e state_q, state_d;

  logic [LenW-1:0]       mem_q [Depth];
  logic [LenW-1:0]       rdata_q;
  logic                  rd_en, wr_en;
  logic [VALUE_BITS-1:0] rd_addr, wr_addr;
  logic [LenW-1:0]       wr_data;

  logic [VALUE_BITS-1:0] clr_q, clr_d;
  logic [VALUE_BITS-1:0] v_q, v_d;
  lcrt_pkg::bound_flags_t flags_q, flags_d;
  logic [LenW-1:0]       below_q, below_d;
  logic [LenW-1:0]       len_q, len_d;
  logic [VALUE_BITS-1:0] hi_q, hi_d;
  logic [LenW-1:0]       best_q, best_d;
  logic [LenW-1:0]       above, best_max;
  logic [VALUE_BITS-1:0] lo_addr;

  logic            out_valid_q;
  logic [LenW-1:0] longest_q, run_q;
  logic            dup_q;
  logic            out_free, load, load_dup;
  logic [LenW-1:0] load_long, load_run;

  assign out_free = !out_valid_q || out_ready_i;
  assign above    = flags_q.at_top ? '0 : rdata_q;
  assign len_d    = LenW'(below_q + above + LenW'(1));
  assign lo_addr  = v_q - below_q[VALUE_BITS-1:0];
  assign hi_d     = v_q + above[VALUE_BITS-1:0];
  assign best_max = (len_q > best_q) ? len_q : best_q;

  always_comb begin
    state_d   = state_q;
    clr_d     = clr_q;
    v_d       = v_q;
    flags_d   = flags_q;
    below_d   = below_q;
    best_d    = best_q;
    rd_en     = 1'b0;
    rd_addr   = v_q;
    wr_en     = 1'b0;
    wr_addr   = v_q;
    wr_data   = len_q;
    load      = 1'b0;
    load_long = best_q;
    load_run  = len_q;
    load_dup  = 1'b0;
    back_ctrl_o.clearing = 1'b0;
    back_ctrl_o.pop      = 1'b0;
    unique case (state_q)
      S_CLEAR: begin
        back_ctrl_o.clearing = 1'b1;
        wr_en   = 1'b1;
        wr_addr = clr_q;
        wr_data = '0;
        clr_d   = clr_q + VALUE_BITS'(1);
        if (clr_q == '1) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (q_valid_i) begin
          back_ctrl_o.pop = 1'b1;
          v_d     = q_value_i;
          flags_d = q_flags_i;
          rd_en   = 1'b1;
          rd_addr = q_value_i;
          state_d = S_CHK;
        end
      end
      S_CHK: begin
        // rdata holds the entry of v itself
        if (rdata_q != '0) begin
          if (out_free) begin
            load      = 1'b1;
            load_long = best_q;
            load_run  = '0;
            load_dup  = 1'b1;
            state_d   = S_IDLE;
          end
        end else begin
          rd_en   = 1'b1;
          rd_addr = v_q - VALUE_BITS'(1);
          state_d = S_BELOW;
        end
      end
      S_BELOW: begin
        // mark v present now; endpoint writes overwrite it if v is an end
        below_d = flags_q.at_bottom ? '0 : rdata_q;
        rd_en   = 1'b1;
        rd_addr = v_q + VALUE_BITS'(1);
        wr_en   = 1'b1;
        wr_addr = v_q;
        wr_data = LenW'(1);
        state_d = S_LO;
      end
      S_LO: begin
        wr_en   = 1'b1;
        wr_addr = lo_addr;
        wr_data = len_d;
        state_d = S_HI;
      end
      S_HI: begin
        wr_en   = 1'b1;
        wr_addr = hi_q;
        wr_data = len_q;
        if (out_free) begin
          load      = 1'b1;
          load_long = best_max;
          load_run  = len_q;
          best_d    = best_max;
          state_d   = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      clr_q       <= '0;
      best_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      clr_q   <= clr_d;
      best_q  <= best_d;
      if (load) out_valid_q <= 1'b1;
      else if (out_ready_i) out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    v_q     <= v_d;
    flags_q <= flags_d;
    below_q <= below_d;
    if (state_q == S_LO) begin
      len_q <= len_d;
      hi_q  <= hi_d;
    end
    if (load) begin
      longest_q <= load_long;
      run_q     <= load_run;
      dup_q     <= load_dup;
    end
  end

  // run-length table, one write and one registered read port
  always_ff @(posedge clk_i) begin
    if (wr_en) mem_q[wr_addr] <= wr_data;
    if (rd_en) rdata_q <= mem_q[rd_addr];
  end

  assign out_valid_o  = out_valid_q;
  assign longest_o    = longest_q;
  assign run_length_o = run_q;
  assign duplicate_o  = dup_q;

  `LCRT_ASSERT(a_best_monotonic, best_q >= $past(best_q), "best run decreased")
  `LCRT_ASSERT(a_lo_below_v, (state_q == S_LO) |-> (lo_addr <= v_q), "run start above value")
  `LCRT_ASSERT(a_hi_above_v, (state_q == S_LO) |-> (hi_d >= v_q), "run end wrapped")
  `LCRT_ASSERT(a_result_source,
               $rose(out_valid_q) |-> ($past(state_q) == S_CHK || $past(state_q) == S_HI),
               "result loaded from wrong state")
  `LCRT_ASSERT_NR(a_no_result_in_clear, (state_q == S_CLEAR) |-> !out_valid_q,
                  "result during clearing pass")

endmodule

// ----- dv/testbench.sv -----
// Self-checking testbench for longest_consecutive_run_tracker.
// Needs only the RTL: a directed table, then ~1800 random words, scored against an
// in-bench model of the run-length table or, for typed rows, hand-written results.
`timescale 1ns / 100ps

module testbench;

  localparam int unsigned VALUE_BITS = 10;
  localparam int unsigned TABLE_DEPTH = 1 << VALUE_BITS;
  localparam int unsigned RANDOM_WORDS = 1800;
  // Watchdog: cycles with no word moving on either side. Covers the
  // table clear after reset with plenty of margin.
  localparam int unsigned STALL_LIMIT = 5000;
  localparam int unsigned DRAIN_CYCLES = 20;

  typedef logic [VALUE_BITS-1:0] value_t;
  typedef logic [VALUE_BITS:0] len_t;

  // One result word as the block reports it.
  typedef struct packed {
    len_t longest;
    len_t run_len;
    logic dup;
  } run_report_t;

  // One row of the directed table. 'typed' rows carry a hand-written result.
  typedef struct packed {
    value_t value;
    logic typed;
    run_report_t want;
  } seed_row_t;

  localparam int unsigned SEED_COUNT = 21;
  localparam seed_row_t SEED_ROWS [SEED_COUNT] = '{
    // fresh table: both range edges start singleton runs
    '{10'd0,    1'b1, '{11'd1, 11'd1, 1'b0}},
    '{10'd1023, 1'b1, '{11'd1, 11'd1, 1'b0}},
    // repeats of edge values: flagged, length 0, best unchanged
    '{10'd0,    1'b1, '{11'd1, 11'd0, 1'b1}},
    '{10'd1023, 1'b1, '{11'd1, 11'd0, 1'b1}},
    // growing inward from each edge
    '{10'd1,    1'b1, '{11'd2, 11'd2, 1'b0}},
    '{10'd1022, 1'b1, '{11'd2, 11'd2, 1'b0}},
    // islands, then a value that bridges both sides
    '{10'd5,    1'b0, '0},
    '{10'd7,    1'b0, '0},
    '{10'd6,    1'b0, '0},
    '{10'd6,    1'b0, '0},
    '{10'd3,    1'b0, '0},
    '{10'd4,    1'b0, '0},
    '{10'd2,    1'b0, '0},
    // mid-range bridge, then repeat of an interior value
    '{10'd512,  1'b0, '0},
    '{10'd510,  1'b0, '0},
    '{10'd511,  1'b0, '0},
    '{10'd511,  1'b0, '0},
    // join onto the top-edge run from below
    '{10'd1020, 1'b0, '0},
    '{10'd1021, 1'b0, '0},
    '{10'd9,    1'b0, '0},
    '{10'd8,    1'b0, '0}
  };

  logic   clk_i;
  logic   rst_ni;
  logic   in_valid_i;
  logic   in_ready_o;
  value_t value_i;
  logic   out_valid_o;
  logic   out_ready_i;
  len_t   longest_o;
  len_t   run_length_o;
  logic   duplicate_o;

  longest_consecutive_run_tracker #(
    .VALUE_BITS(VALUE_BITS)
  ) dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .value_i     (value_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .longest_o   (longest_o),
    .run_length_o(run_length_o),
    .duplicate_o (duplicate_o)
  );

  // Bench copy of the block state: run lengths by value, plus best so far.
  len_t        run_len_tbl [TABLE_DEPTH];
  len_t        best_len;
  // Results owed by the block, oldest first.
  run_report_t pending_reports [$];
  int unsigned mismatch_cnt;
  int unsigned stall_cycles;
  // Set during a stretch where neither side idles.
  logic        steady;

  initial clk_i = 1'b0;
  always #2 clk_i = ~clk_i;

  // Add one value to the bench table and return what the block should report.
  // Only run endpoints hold exact lengths; interior entries just mark presence.
  function automatic run_report_t join_value(value_t v);
    len_t        below;
    len_t        above;
    len_t        len;
    value_t      lo;
    value_t      hi;
    run_report_t rep;
    below = '0;
    above = '0;
    if (run_len_tbl[v] != '0) begin
      rep.longest = best_len;
      rep.run_len = '0;
      rep.dup = 1'b1;
      return rep;
    end
    // No wrap: nothing lies beyond either edge of the range.
    if (v != '0) below = run_len_tbl[v - 1'b1];
    if (v != '1) above = run_len_tbl[v + 1'b1];
    len = below + above + 1'b1;
    lo = v - value_t'(below);
    hi = v + value_t'(above);
    run_len_tbl[v] = len;
    run_len_tbl[lo] = len;
    run_len_tbl[hi] = len;
    if (len > best_len) best_len = len;
    rep.longest = best_len;
    rep.run_len = len;
    rep.dup = 1'b0;
    return rep;
  endfunction

  // Next value not yet in the set at or after 'start', wrapping; falls back
  // to 'start' once the set is full.
  function automatic value_t next_absent(value_t start);
    value_t v;
    v = start;
    for (int unsigned n = 0; n < TABLE_DEPTH; n++) begin
      if (run_len_tbl[v] == '0) return v;
      v = v + 1'b1;
    end
    return start;
  endfunction

  // Offer one word; on acceptance, score it and queue the expected result.
  task automatic push_value(value_t v, logic typed, run_report_t want);
    run_report_t rep;
    // random gaps before the word, junk on the data lines meanwhile
    while (!steady && $urandom_range(99) < 7) begin
      @(negedge clk_i);
      in_valid_i <= 1'b0;
      value_i <= value_t'($urandom);
    end
    @(negedge clk_i);
    in_valid_i <= 1'b1;
    value_i <= v;
    do @(posedge clk_i); while (!in_ready_o);
    rep = join_value(v);
    if (typed) rep = want;
    pending_reports = {pending_reports, rep};
  endtask

  // Receiver: stalls at random (about 7 draws in 100), never during the steady stretch.
  always @(negedge clk_i) begin
    out_ready_i <= steady || ($urandom_range(99) >= 7);
  end

  // Result scoreboard and watchdog, both on the rising edge.
  always @(posedge clk_i) begin
    run_report_t want;
    if (!rst_ni) begin
      stall_cycles = 0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        if (pending_reports.size() == 0) begin
          $error("result word with no expectation pending");
          mismatch_cnt++;
        end else begin
          want = pending_reports.pop_front();
          if (longest_o !== want.longest) begin
            $error("longest: expected %0d, got %0d", want.longest, longest_o);
            mismatch_cnt++;
          end
          if (run_length_o !== want.run_len) begin
            $error("run_length: expected %0d, got %0d", want.run_len, run_length_o);
            mismatch_cnt++;
          end
          if (duplicate_o !== want.dup) begin
            $error("duplicate: expected %0d, got %0d", want.dup, duplicate_o);
            mismatch_cnt++;
          end
        end
      end
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
        stall_cycles = 0;
      end else begin
        stall_cycles++;
      end
      if (stall_cycles >= STALL_LIMIT) begin
        $error("no word moved for %0d cycles", STALL_LIMIT);
        $display("== FAIL ==");
        $finish;
      end
    end
  end

  initial begin
    value_t      v;
    value_t      last_v;
    int unsigned mode;
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    value_i = '0;
    out_ready_i = 1'b0;
    steady = 1'b0;
    mismatch_cnt = 0;
    stall_cycles = 0;
    best_len = '0;
    last_v = '0;
    foreach (run_len_tbl[i]) run_len_tbl[i] = '0;

    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed table: edges, repeats, joins from below, above and both sides.
    for (int unsigned i = 0; i < SEED_COUNT; i++) begin
      push_value(SEED_ROWS[i].value, SEED_ROWS[i].typed, SEED_ROWS[i].want);
    end

    // Random part. Mix of uniform draws, near neighbours of the last value
    // (builds runs and hits the edges through wrap of the offset), and gap
    // filling that bridges runs.
    for (int unsigned i = 0; i < RANDOM_WORDS; i++) begin
      steady = (i >= 700 && i < 1000);
      mode = $urandom_range(9);
      if (mode < 4) begin
        v = value_t'($urandom_range(TABLE_DEPTH - 1));
      end else if (mode < 7) begin
        case ($urandom_range(3))
          0: v = last_v - 2'd2;
          1: v = last_v - 1'b1;
          2: v = last_v + 1'b1;
          default: v = last_v + 2'd2;
        endcase
      end else begin
        v = next_absent(value_t'($urandom_range(TABLE_DEPTH - 1)));
      end
      last_v = v;
      push_value(v, 1'b0, '0);
    end
    steady = 1'b0;
    @(negedge clk_i);
    in_valid_i <= 1'b0;

    // Drain; the watchdog ends the run if results stop coming.
    while (pending_reports.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (mismatch_cnt == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
